// File: rtl/vdu_pkg.sv
// Shared types and constants for the vector distance unit.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package vdu_pkg;

    localparam int ELEM_W   = 16;
    localparam int AD_W     = 16;
    localparam int ACC_W    = 43;
    localparam int DIST_W   = 26;
    localparam int METRIC_W = 2;
    localparam int MAX_LEN  = 1024;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // Largest distance the output reports: min(65535 * MAX_LEN, 2^26 - 1).
    localparam longint DIST_TOP_L = (65535 * longint'(MAX_LEN) > (longint'(1) << DIST_W) - 1)
                                    ? (longint'(1) << DIST_W) - 1
                                    : 65535 * longint'(MAX_LEN);
    localparam logic [DIST_W-1:0] DIST_TOP = DIST_W'(DIST_TOP_L);

    // Square root: one result bit per unstalled cycle; 44-bit radicand.
    localparam int RAD_W      = ACC_W + 1;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [METRIC_W-1:0] {
        METRIC_EUCLID    = 2'd0,
        METRIC_CHEBYSHEV = 2'd1,
        METRIC_MANHATTAN = 2'd2,
        METRIC_SPARE     = 2'd3
    } t_metric;

    // One finished vector handed from the front to the back.
    typedef struct packed {
        logic             is_root;
        logic [ACC_W-1:0] acc;
    } t_job;

    typedef enum logic {
        BK_IDLE,
        BK_ROOT
    } t_back_state;

endpackage

// File: rtl/vector_distance_unit.sv
// Top level of the vector distance unit: front, job queue and back part.
// Depends on vdu_pkg, vdu_front, vdu_queue and vdu_back.
//
//   channel   handshake                   payload
//   -------   -------------------------   ------------------------------------
//   config    i_cfg_we                    i_cfg_data (metric)
//   input     i_in_valid / o_in_stall     i_elem_a, i_elem_b, i_last
//   output    o_out_valid / i_out_stall   o_distance
//
// One element pair per cycle is taken unless o_in_stall is high; its |a - b|
// is registered and then added to the accumulator. Chebyshev and Manhattan
// words go from the job queue straight to the output register. Euclidean words
// first take a load step and 22 one-bit root steps; no job is popped meanwhile.
// A two-entry job queue lets the front keep streaming while the root runs;
// the input stalls only when a final pair finds that queue full.
// Reset is synchronous, active low, and clears the accumulator and metric.
`timescale 1ns / 1ps

module vector_distance_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [vdu_pkg::METRIC_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [vdu_pkg::ELEM_W-1:0]   i_elem_a,
    input  logic [vdu_pkg::ELEM_W-1:0]   i_elem_b,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [vdu_pkg::DIST_W-1:0]   o_distance
);
    import vdu_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    vdu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_elem_a   (i_elem_a),
        .i_elem_b   (i_elem_b),
        .i_last     (i_last),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    vdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    vdu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance)
    );

endmodule

// File: rtl/vdu_front.sv
// Front part: takes element pairs, forms |a - b| and keeps the running accumulator.
// Hands each finished vector to the job queue. Depends on vdu_pkg.
`timescale 1ns / 1ps

module vdu_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [vdu_pkg::METRIC_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [vdu_pkg::ELEM_W-1:0]   i_elem_a,
    input  logic [vdu_pkg::ELEM_W-1:0]   i_elem_b,
    input  logic                         i_last,
    output logic                         o_push,
    output vdu_pkg::t_job                o_job,
    input  logic                         i_full
);
    import vdu_pkg::*;

    t_metric           r_metric;
    logic              r_a_valid;
    logic [AD_W-1:0]   r_ad;
    logic              r_a_last;
    logic [ACC_W-1:0]  r_acc;

    logic [ELEM_W:0]   diff;
    logic [ELEM_W:0]   diff_abs;
    logic              a_adv;
    logic              in_take;
    logic [2*AD_W-1:0] square;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  acc_upd;

    assign diff     = {i_elem_a[ELEM_W-1], i_elem_a} - {i_elem_b[ELEM_W-1], i_elem_b};
    assign diff_abs = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;

    // The accumulate stage only waits when a final pair meets a full queue.
    assign a_adv      = r_a_valid && !(r_a_last && i_full);
    assign o_in_stall = r_a_valid && !a_adv;
    assign in_take    = i_in_valid && !o_in_stall;

    assign square = r_ad * r_ad;

    always_comb begin
        sum     = '0;
        acc_upd = r_acc;
        unique case (r_metric)
            METRIC_EUCLID: begin
                sum     = {1'b0, r_acc} + (ACC_W+1)'(square);
                acc_upd = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            end
            METRIC_CHEBYSHEV: begin
                acc_upd = (ACC_W'(r_ad) > r_acc) ? ACC_W'(r_ad) : r_acc;
            end
            METRIC_MANHATTAN, METRIC_SPARE: begin
                sum     = {1'b0, r_acc} + (ACC_W+1)'(r_ad);
                acc_upd = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            end
            default: acc_upd = r_acc;
        endcase
    end

    assign o_push      = a_adv && r_a_last;
    assign o_job.acc     = acc_upd;
    assign o_job.is_root = (r_metric == METRIC_EUCLID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric  <= METRIC_EUCLID;
            r_a_valid <= 1'b0;
            r_acc     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_metric <= t_metric'(i_cfg_data);
            end
            if (in_take) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_acc <= r_a_last ? '0 : acc_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ad     <= diff_abs[AD_W-1:0];
            r_a_last <= i_last;
        end
    end

endmodule

// File: rtl/vdu_queue.sv
// Short job queue between the front and the back parts.
// Show-ahead read; depends on vdu_pkg.
`timescale 1ns / 1ps

module vdu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vdu_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output vdu_pkg::t_job o_job,
    output logic          o_empty
);
    import vdu_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/vdu_back.sv
// Back part: turns a finished accumulator into a distance word.
// Bit-serial square root for Euclidean, clamp, output register. Depends on vdu_pkg.
`timescale 1ns / 1ps

module vdu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vdu_pkg::t_job              i_job,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [vdu_pkg::DIST_W-1:0] o_distance
);
    import vdu_pkg::*;

    t_back_state       r_state, n_state;
    logic [RAD_W-1:0]  r_val, n_val;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_out_dist, n_out_dist;

    logic              out_free;
    logic              last_step;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;
    logic [REM_W+1:0]  rem_step;
    logic [ROOT_W-1:0] root_step;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_step = (r_cnt == CNT_W'(ROOT_STEPS - 1));

    // One root bit per unstalled cycle: bring down two radicand bits, try root*4+1.
    assign rem_sh    = {r_rem, r_val[RAD_W-1 -: 2]};
    assign trial     = (REM_W+2)'({r_root, 2'b01});
    assign fits      = (rem_sh >= trial);
    assign rem_step  = fits ? rem_sh - trial : rem_sh;
    assign root_step = {r_root[ROOT_W-2:0], fits};

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_root      = r_root;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_dist  = r_out_dist;
        o_pop       = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_job.is_root) begin
                        n_val   = RAD_W'(i_job.acc);
                        n_root  = '0;
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = BK_ROOT;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_dist  = (i_job.acc > ACC_W'(DIST_TOP))
                                      ? DIST_TOP : i_job.acc[DIST_W-1:0];
                    end
                end
            end
            BK_ROOT: begin
                if (!last_step || out_free) begin
                    n_val  = {r_val[RAD_W-3:0], 2'b00};
                    n_root = root_step;
                    n_rem  = rem_step[REM_W-1:0];
                    n_cnt  = r_cnt + 1'b1;
                    if (last_step) begin
                        n_out_valid = 1'b1;
                        n_out_dist  = (DIST_W'(root_step) > DIST_TOP)
                                      ? DIST_TOP : DIST_W'(root_step);
                        n_state     = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_root     <= n_root;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_out_dist <= n_out_dist;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;

endmodule
